@@ rtl/lfutc_pkg.sv @@
// Package of the LFU table cache tag store: field widths, the count limit,
// transfer structures between the controller and the store, and the state type.
// Depends on nothing else.
package lfutc_pkg;

    localparam int WAYS_DEF = 16;
    localparam int KEY_W    = 63;
    localparam int CNT_W    = 32;
    localparam int WAY_W    = 4;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = 32'hffff_ffff;
    localparam logic [CNT_W-1:0] COUNT_FIRST = 32'd1;

    // Write request to the tag and count memories.
    typedef struct packed {
        logic             tag_en;
        logic             cnt_en;
        logic [KEY_W-1:0] tag;
        logic [CNT_W-1:0] cnt;
    } t_wr_req;

    // Registered read response; an entry not yet written reads as empty.
    typedef struct packed {
        logic             live;
        logic             vld;
        logic [KEY_W-1:0] tag;
        logic [CNT_W-1:0] cnt;
    } t_rd_rsp;

    // One result item.
    typedef struct packed {
        logic [KEY_W-1:0] displaced_key;
        logic [WAY_W-1:0] way_index;
        logic             hit;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INC,
        S_HALVE,
        S_MISS,
        S_DONE
    } t_state;

endpackage

@@ rtl/lfutc_store.sv @@
// Tag and use-count memories of the LFU table cache, one read and one write
// port each, read data registered, plus per-way valid flags cleared at reset.
// Depends on lfutc_pkg.
module lfutc_store import lfutc_pkg::*; #(
    parameter int WAYS = WAYS_DEF,
    localparam int AW  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  t_wr_req       i_wr,
    input  logic [AW-1:0] i_wr_addr,
    output t_rd_rsp       o_rsp,
    output logic [AW-1:0] o_rsp_idx
);

    logic [KEY_W-1:0] mem_tag [WAYS];
    logic [CNT_W-1:0] mem_cnt [WAYS];
    logic [WAYS-1:0]  r_valid;

    logic [KEY_W-1:0] r_rd_tag;
    logic [CNT_W-1:0] r_rd_cnt;
    logic             r_rd_vld;
    logic             r_rd_live;
    logic [AW-1:0]    r_rd_idx;

    // Memory writes and the registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.tag_en) begin
            mem_tag[i_wr_addr] <= i_wr.tag;
        end
        if (i_wr.cnt_en) begin
            mem_cnt[i_wr_addr] <= i_wr.cnt;
        end
        if (i_rd_en) begin
            r_rd_tag <= mem_tag[i_rd_addr];
            r_rd_cnt <= mem_cnt[i_rd_addr];
            r_rd_vld <= r_valid[i_rd_addr];
            r_rd_idx <= i_rd_addr;
        end
    end

    // A way becomes valid when its tag is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= i_rd_en;
            if (i_wr.tag_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Ways never written read as empty with a zero count.
    always_comb begin
        o_rsp.live = r_rd_live;
        o_rsp.vld  = r_rd_vld;
        o_rsp.tag  = r_rd_vld ? r_rd_tag : '0;
        o_rsp.cnt  = r_rd_vld ? r_rd_cnt : '0;
    end

    assign o_rsp_idx = r_rd_idx;

endmodule

@@ rtl/lfutc_ctrl.sv @@
// Request sequencer of the LFU table cache: scans the ways for a match and the
// least used way, updates counts, runs the halving pass and forms the result.
// Depends on lfutc_pkg.
module lfutc_ctrl import lfutc_pkg::*; #(
    parameter int WAYS = WAYS_DEF,
    localparam int AW  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_in_ready,
    input  logic             i_out_free,
    output logic             o_res_valid,
    output t_result          o_res,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    output t_wr_req          o_wr,
    output logic [AW-1:0]    o_wr_addr,
    input  t_rd_rsp          i_rsp,
    input  logic [AW-1:0]    i_rsp_idx
);

    localparam logic [AW:0]   ISSUE_END = (AW+1)'(WAYS);
    localparam logic [AW-1:0] LAST_WAY  = AW'(WAYS - 1);

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AW:0]      r_issue, n_issue;
    logic [CNT_W-1:0] r_best_cnt, n_best_cnt;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    logic [KEY_W-1:0] r_best_tag, n_best_tag;
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    logic [CNT_W-1:0] r_inc, n_inc;
    t_result          r_res, n_res;

    logic w_issue;
    logic w_match;
    logic w_last;
    logic w_better;

    // Way number cut or widened to the result field.
    function automatic logic [WAY_W-1:0] way_field(input logic [AW-1:0] idx);
        logic [AW+WAY_W-1:0] ext;
        ext = {{WAY_W{1'b0}}, idx};
        return ext[WAY_W-1:0];
    endfunction

    // Scan decisions on the response of the memory read.
    assign w_issue  = ((r_state == S_SCAN) || (r_state == S_HALVE)) && (r_issue < ISSUE_END);
    assign w_match  = i_rsp.live && (i_rsp.tag != '0) && (i_rsp.tag == r_key);
    assign w_last   = i_rsp.live && (i_rsp_idx == LAST_WAY);
    assign w_better = (i_rsp_idx == '0) || (i_rsp.cnt < r_best_cnt);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_key == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_state = S_INC;
                end else if (w_last) begin
                    n_state = S_MISS;
                end
            end
            S_INC: begin
                n_state = (r_inc == COUNT_LIMIT) ? S_HALVE : S_DONE;
            end
            S_HALVE: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_MISS: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers: key, scan position, best candidate, match, result.
    always_comb begin
        n_key      = r_key;
        n_issue    = w_issue ? r_issue + 1'b1 : r_issue;
        n_best_cnt = r_best_cnt;
        n_best_idx = r_best_idx;
        n_best_tag = r_best_tag;
        n_hit_idx  = r_hit_idx;
        n_inc      = r_inc;
        n_res      = r_res;
        unique case (r_state)
            S_IDLE: begin
                n_key   = i_key;
                n_issue = '0;
                n_res   = '0;
            end
            S_SCAN: begin
                if (w_match) begin
                    n_hit_idx = i_rsp_idx;
                    n_inc     = i_rsp.cnt + 1'b1;
                end else if (i_rsp.live && w_better) begin
                    n_best_cnt = i_rsp.cnt;
                    n_best_idx = i_rsp_idx;
                    n_best_tag = i_rsp.tag;
                end
            end
            S_INC: begin
                n_issue             = '0;
                n_res.hit           = 1'b1;
                n_res.way_index     = way_field(r_hit_idx);
                n_res.displaced_key = '0;
            end
            S_MISS: begin
                n_res.hit           = 1'b0;
                n_res.way_index     = way_field(r_best_idx);
                n_res.displaced_key = r_best_tag;
            end
            S_HALVE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Memory accesses and handshake outputs.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE) && i_out_free;
        o_res       = r_res;
        o_rd_en     = w_issue;
        o_rd_addr   = r_issue[AW-1:0];
        o_wr        = '0;
        o_wr_addr   = r_best_idx;
        unique case (r_state)
            S_INC: begin
                o_wr.cnt_en = 1'b1;
                o_wr.cnt    = r_inc;
                o_wr_addr   = r_hit_idx;
            end
            S_HALVE: begin
                o_wr.cnt_en = i_rsp.live && i_rsp.vld;
                o_wr.cnt    = i_rsp.cnt >> 1;
                o_wr_addr   = i_rsp_idx;
            end
            S_MISS: begin
                o_wr.tag_en = 1'b1;
                o_wr.cnt_en = 1'b1;
                o_wr.tag    = r_key;
                o_wr.cnt    = COUNT_FIRST;
                o_wr_addr   = r_best_idx;
            end
            S_IDLE, S_SCAN, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_issue    <= n_issue;
        r_best_cnt <= n_best_cnt;
        r_best_idx <= n_best_idx;
        r_best_tag <= n_best_tag;
        r_hit_idx  <= n_hit_idx;
        r_inc      <= n_inc;
        r_res      <= n_res;
    end

`ifndef NO_ASSERTIONS
    // A tag is only ever written with a nonzero key and a fresh count.
    a_tag_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.tag_en |-> (o_wr.tag != '0) && (o_wr.cnt == COUNT_FIRST))
        else $error("tag write with zero key or wrong count");

    // A hit result never reports a displaced key.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.hit) |-> (o_res.displaced_key == '0))
        else $error("hit result carries a displaced key");

    // Reaching the count limit starts the halving pass.
    a_halve_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INC && r_inc == COUNT_LIMIT) |=> (r_state == S_HALVE))
        else $error("count limit reached without halving");

    // No memory write while a new request could be accepted.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_wr.tag_en || o_wr.cnt_en))
        else $error("memory write while idle");
`endif

endmodule

@@ rtl/lfu_table_cache_tags_core.sv @@
// A request with a zero key gives its result without a memory scan; a hit or a
// miss gives it after the scan, which stops at a matching way, and a hit that
// reaches the count limit adds a halving pass over every way before the result.
// One request at a time: the memory scan reads one entry per cycle, and a new
// request waits until the result reaches the output register. Reset (i_rst_n,
// synchronous, active low) empties every way at once; empty ways read count zero.
module lfu_table_cache_tags_core import lfutc_pkg::*; #(
    parameter int WAYS = WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: tdata = table_key[62:0], zero padding [63].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,
    // Master side: tdata = hit[0], way_index[4:1], displaced_key[67:5],
    // zero padding [71:68].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata
);

    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_wr_req       w_wr;
    logic [AW-1:0] w_wr_addr;
    t_rd_rsp       w_rsp;
    logic [AW-1:0] w_rsp_idx;
    logic          w_out_free;
    logic          w_res_valid;
    t_result       w_res;

    logic          r_m_tvalid;
    t_result       r_m_data;

    assign w_out_free = !r_m_tvalid || i_m_tready;

    lfutc_ctrl #(.WAYS(WAYS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_key       (i_s_tdata[KEY_W-1:0]),
        .o_in_ready  (o_s_tready),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .o_wr        (w_wr),
        .o_wr_addr   (w_wr_addr),
        .i_rsp       (w_rsp),
        .i_rsp_idx   (w_rsp_idx)
    );

    lfutc_store #(.WAYS(WAYS)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .o_rsp     (w_rsp),
        .o_rsp_idx (w_rsp_idx)
    );

    // Output register: holds a result until the master side takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_data <= w_res;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {4'b0000, r_m_data};

endmodule
